/* sv/cmc_pkg.sv */
// Package with the mode codes, register indexes and beat layouts of the charger mode controller.
`timescale 1ns / 1ps

package cmc_pkg;

	// Charger operating modes, as carried on the result beat.
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_CRG_INT = 3'd1,
		MODE_CRG_EXT = 3'd2,
		MODE_JUMP    = 3'd3,
		MODE_CRG_ERR = 3'd4,
		MODE_ERROR   = 3'd5
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_INT_BAT_LOW  = 3'd0,
		REG_REV_POLARITY = 3'd1,
		REG_BAT_DETECT   = 3'd2,
		REG_EXT_FULL     = 3'd3,
		REG_TEMP_LIMIT   = 3'd4,
		REG_TEMP_RECOVER = 3'd5
	} reg_idx_t;

	localparam int MV_W      = 16;
	localparam int TEMP_W    = 8;
	localparam int CFG_W     = 16;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 8;

	// Register reset values.
	localparam logic [MV_W-1:0]          INT_BAT_LOW_RST  = 16'd11500;
	localparam logic [MV_W-1:0]          REV_POLARITY_RST = 16'd16000;
	localparam logic [MV_W-1:0]          BAT_DETECT_RST   = 16'd3000;
	localparam logic [MV_W-1:0]          EXT_FULL_RST     = 16'd14400;
	localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST   = 8'sd60;
	localparam logic signed [TEMP_W-1:0] TEMP_RECOVER_RST = 8'sd50;

	// One measurement tick as held in the input register.
	typedef struct packed {
		logic                     jump_pin;
		logic                     dc_present;
		logic signed [TEMP_W-1:0] temp_c;
		logic [MV_W-1:0]          ext_mv;
		logic [MV_W-1:0]          int_bat_mv;
	} tick_t;

endpackage

/* sv/charger_mode_controller.sv */
// Top level of the charger mode controller: input register, mode update and result register.
`timescale 1ns / 1ps
// A tick accepted into the input register has its mode loaded into the result register when
// it advances, which a stalled result beat can hold off; m_tdata then carries that mode.
// Throughput: one tick per cycle while m_tready holds high; the mode register is updated in the
// same cycle that a tick moves from the input register to the result register.
// Reset (arst_n low): mode returns to idle, both stages empty, thresholds reload
// their default values.

module charger_mode_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	// measurement ticks
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [15:0] int_bat_mv, [31:16] ext_mv, [39:32] temp_c, [40] dc_present,
	// [41] jump_pin, [47:42] zero
	input  logic [cmc_pkg::S_TDATA_W-1:0] s_tdata,
	// new mode per tick
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] mode, [7:3] zero
	output logic [cmc_pkg::M_TDATA_W-1:0] m_tdata,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [cmc_pkg::CFG_W-1:0]     cfg_wdata
);

	import cmc_pkg::*;

	// Threshold registers.
	logic [MV_W-1:0]          int_bat_low_q;
	logic [MV_W-1:0]          rev_polarity_q;
	logic [MV_W-1:0]          bat_detect_q;
	logic [MV_W-1:0]          ext_full_q;
	logic signed [TEMP_W-1:0] temp_limit_q;
	logic signed [TEMP_W-1:0] temp_recover_q;

	// Stage 1: input register. Stage 2: result register.
	tick_t tick_s1;
	logic  valid_s1;
	mode_t mode_s2;
	logic  valid_s2;

	// Mode carried from tick to tick.
	mode_t mode_q;
	mode_t mode_d;

	logic advance_s1;
	logic load_s2;

	// Compare results for the tick in stage 1.
	logic temp_ok;
	logic temp_hot;
	logic no_rp;
	logic rp_over;
	logic rp_reach;
	logic ext_det;
	logic ext_gone;
	logic ext_low;
	logic ext_full;
	logic ib_low;
	logic ib_high;
	logic jump_req;
	logic recover_ok;

	// ------------------------------------------------------------------
	// Configuration: take a write whenever enabled; unknown indexes drop.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_bat_low_q  <= INT_BAT_LOW_RST;
			rev_polarity_q <= REV_POLARITY_RST;
			bat_detect_q   <= BAT_DETECT_RST;
			ext_full_q     <= EXT_FULL_RST;
			temp_limit_q   <= TEMP_LIMIT_RST;
			temp_recover_q <= TEMP_RECOVER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INT_BAT_LOW:  int_bat_low_q  <= cfg_wdata;
				REG_REV_POLARITY: rev_polarity_q <= cfg_wdata;
				REG_BAT_DETECT:   bat_detect_q   <= cfg_wdata;
				REG_EXT_FULL:     ext_full_q     <= cfg_wdata;
				REG_TEMP_LIMIT:   temp_limit_q   <= cfg_wdata[TEMP_W-1:0];
				REG_TEMP_RECOVER: temp_recover_q <= cfg_wdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: stage 2 frees when empty or its beat is taken; stage 1
	// advances into it, and the input side takes a beat whenever stage 1
	// is empty or advancing.
	// ------------------------------------------------------------------
	assign load_s2    = !valid_s2 || m_tready;
	assign advance_s1 = valid_s1 && load_s2;
	assign s_tready   = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload holds while stage 1 is stalled.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= tick_t'(s_tdata[$bits(tick_t)-1:0]);
		end
	end

	// ------------------------------------------------------------------
	// Compares on the held tick.
	// ------------------------------------------------------------------
	assign temp_ok    = tick_s1.temp_c < temp_limit_q;
	assign temp_hot   = tick_s1.temp_c > temp_limit_q;
	assign recover_ok = tick_s1.temp_c < temp_recover_q;
	assign no_rp      = tick_s1.ext_mv <= rev_polarity_q;
	assign rp_over    = tick_s1.ext_mv > rev_polarity_q;
	assign rp_reach   = tick_s1.ext_mv >= rev_polarity_q;
	assign ext_det    = tick_s1.ext_mv >= bat_detect_q;
	assign ext_gone   = tick_s1.ext_mv <= bat_detect_q;
	assign ext_low    = tick_s1.ext_mv < bat_detect_q;
	assign ext_full   = tick_s1.ext_mv > ext_full_q;
	assign ib_low     = tick_s1.int_bat_mv < int_bat_low_q;
	assign ib_high    = tick_s1.int_bat_mv > int_bat_low_q;
	assign jump_req   = !tick_s1.jump_pin;

	// ------------------------------------------------------------------
	// Mode update. A temperature at or above the limit forces error first; the error rules
	// then run in the same tick, so a recover threshold above the limit
	// can clear it at once.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (advance_s1) begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_t m;
		m      = temp_ok ? mode_q : MODE_ERROR;
		mode_d = m;
		unique case (m)
			MODE_IDLE: begin
				if (tick_s1.dc_present && ib_low && no_rp && temp_ok) begin
					mode_d = MODE_CRG_INT;
				end else if (tick_s1.dc_present && ib_high && ext_det && no_rp
						&& !jump_req && temp_ok) begin
					mode_d = MODE_CRG_EXT;
				end else if (ib_high && ext_det && no_rp && jump_req && temp_ok) begin
					mode_d = MODE_JUMP;
				end else if (rp_reach || temp_hot) begin
					mode_d = MODE_ERROR;
				end
			end
			MODE_CRG_INT: begin
				if (!tick_s1.dc_present || !temp_ok) begin
					mode_d = MODE_ERROR;
				end else if (ib_high) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_CRG_EXT: begin
				if (temp_hot) begin
					mode_d = MODE_ERROR;
				end else if (!tick_s1.dc_present) begin
					mode_d = MODE_CRG_ERR;
				end else if (ext_full) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_JUMP: begin
				if (rp_over || !temp_ok) begin
					mode_d = MODE_ERROR;
				end else if (ib_low || ext_low) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_CRG_ERR: begin
				if (tick_s1.dc_present || ext_gone) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_ERROR: begin
				if (!rp_reach && recover_ok) begin
					mode_d = MODE_IDLE;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			mode_s2 <= mode_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W-$bits(mode_t)){1'b0}}, mode_s2};

endmodule

/* sv/cmc_checker.sv */
// Port-level checks for the charger mode controller and their binding to the top level.
`timescale 1ns / 1ps

module cmc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cmc_pkg::M_TDATA_W-1:0] m_tdata
);

	import cmc_pkg::*;

	// Only the six defined modes ever leave the block.
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7))
		else $error("undefined mode code on result beat");

	// Padding bits of the result beat stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:3] == '0))
		else $error("result padding not zero");

	// With no result waiting, the input side never stalls.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

endmodule

bind charger_mode_controller cmc_checker u_cmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
